@@ hdl/cfa_pkg.sv @@
// ============================================================================
// cfa_pkg - contiguous fit allocator shared definitions
// Field widths, operation and status codes, controller states and the
// command/status bundles between the controller and the datapath.
// ============================================================================
package cfa_pkg;

    localparam int MEM_UNITS_DEF = 64;
    localparam int SLOTS_DEF     = 16;

    // fixed field widths of the request and result transactions
    localparam int FUNC_W   = 2;
    localparam int SIZE_W   = 7;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;
    localparam int START_W  = 6;
    localparam int RUN_W    = 7;

    localparam int S_FIELDS_W = FUNC_W + SIZE_W + SLOT_W;
    localparam int M_FIELDS_W = STATUS_W + START_W + SLOT_W + RUN_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_FIRST = 2'd0,
        FUNC_BEST  = 2'd1,
        FUNC_WORST = 2'd2,
        FUNC_FREE  = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_NOFIT    = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_NOTALLOC = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        FSM_INIT,
        FSM_IDLE,
        FSM_CHECK,
        FSM_SCAN,
        FSM_CLOSE,
        FSM_MARK,
        FSM_FREE_ADDR,
        FSM_FREE_LEN,
        FSM_CLEAR,
        FSM_DONE
    } state_t;

    typedef struct packed {
        logic    init_clear;
        logic    req_load;
        logic    scan_init;
        logic    scan_run;
        logic    close_run;
        logic    cnt_clear;
        logic    mark_step;
        logic    slot_rd;
        logic    free_rd;
        logic    free_len_load;
        logic    clear_step;
        logic    out_load;
        logic    alloc_commit;
        logic    free_commit;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic req_free;
        logic req_reject;
        logic slot_bad;
        logic scan_end;
        logic found;
        logic len_zero;
        logic mark_last;
        logic clear_last;
        logic out_free;
    } sts_t;

endpackage

@@ hdl/cfa_datapath.sv @@
// ============================================================================
// cfa_datapath - unit map, slot table, run scanner and result register
// Executes the controller's commands one step per cycle over the unit map.
// ============================================================================
module cfa_datapath #(
    parameter int MEM_UNITS = cfa_pkg::MEM_UNITS_DEF,
    parameter int SLOTS     = cfa_pkg::SLOTS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cfa_pkg::cmd_t                cmd,
    output cfa_pkg::sts_t                sts,
    input  logic [cfa_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [cfa_pkg::M_TDATA_W-1:0] m_tdata
);
    import cfa_pkg::*;

    localparam int UA_W  = $clog2(MEM_UNITS);
    localparam int UC_W  = $clog2(MEM_UNITS + 1);
    localparam int SA_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SC_W  = $clog2(SLOTS + 1);
    localparam int CMP_W = ((UC_W > SIZE_W) ? UC_W : SIZE_W) + 1;

    // request
    func_t             req_func_reg;
    logic [SIZE_W-1:0] req_size_reg;
    logic [SLOT_W-1:0] req_slot_reg;

    // unit map
    logic [SIZE_W-1:0] unit_mem [MEM_UNITS];
    logic [SIZE_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [UA_W-1:0]   mem_addr;
    logic [SIZE_W-1:0] mem_wdata;

    // slot table
    logic [UA_W-1:0]   slot_mem [SLOTS];
    logic [UA_W-1:0]   slot_rd_reg;
    logic [SLOTS-1:0]  slot_valid_reg;
    logic [SC_W-1:0]   issued_reg;

    // scanner
    logic [UA_W-1:0]   scan_addr_reg;
    logic              issue_done_reg;
    logic              rd_pend_reg;
    logic [UA_W-1:0]   rd_unit_reg;
    logic [UA_W-1:0]   cur_start_reg;
    logic [UC_W-1:0]   cur_len_reg;
    logic [UA_W-1:0]   pick_start_reg;
    logic [UC_W-1:0]   pick_len_reg;
    logic              found_reg;
    logic              eval_en;
    logic              take;

    // shared step counter and freed length
    logic [UC_W-1:0]   cnt_reg;
    logic [SIZE_W-1:0] free_len_reg;

    // result register
    logic                m_tvalid_reg;
    status_t             out_status_reg;
    logic [START_W-1:0]  out_start_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [RUN_W-1:0]    out_run_reg;

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            req_func_reg <= func_t'(s_tdata[FUNC_W-1:0]);
            req_size_reg <= s_tdata[FUNC_W +: SIZE_W];
            req_slot_reg <= s_tdata[FUNC_W+SIZE_W +: SLOT_W];
        end
    end

    // ---- unit map port ----
    always_comb begin
        mem_we    = cmd.init_clear | cmd.mark_step | cmd.clear_step;
        mem_wdata = cmd.mark_step ? req_size_reg : '0;
        if (cmd.init_clear) begin
            mem_addr = cnt_reg[UA_W-1:0];
        end else if (cmd.mark_step) begin
            mem_addr = UA_W'(pick_start_reg + cnt_reg);
        end else if (cmd.clear_step) begin
            mem_addr = UA_W'(slot_rd_reg + cnt_reg);
        end else if (cmd.free_rd) begin
            mem_addr = slot_rd_reg;
        end else begin
            mem_addr = scan_addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            unit_mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= unit_mem[mem_addr];
    end

    // ---- slot table ----
    always_ff @(posedge aclk) begin
        if (cmd.alloc_commit) begin
            slot_mem[SA_W'(issued_reg)] <= pick_start_reg;
        end
        if (cmd.slot_rd) begin
            slot_rd_reg <= slot_mem[SA_W'(req_slot_reg)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            issued_reg     <= '0;
        end else begin
            if (cmd.alloc_commit) begin
                slot_valid_reg[SA_W'(issued_reg)] <= 1'b1;
                issued_reg <= issued_reg + SC_W'(1);
            end
            if (cmd.free_commit) begin
                slot_valid_reg[SA_W'(req_slot_reg)] <= 1'b0;
            end
        end
    end

    // ---- run scanner ----
    always_comb begin
        eval_en = (cmd.scan_run && rd_pend_reg && (rd_data_reg != '0)) || cmd.close_run;
        take    = (CMP_W'(cur_len_reg) >= CMP_W'(req_size_reg)) &&
                  (!found_reg ||
                   ((req_func_reg == FUNC_BEST)  && (cur_len_reg < pick_len_reg)) ||
                   ((req_func_reg == FUNC_WORST) && (cur_len_reg > pick_len_reg)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_done_reg <= 1'b1;
            rd_pend_reg    <= 1'b0;
            found_reg      <= 1'b0;
        end else if (cmd.scan_init) begin
            issue_done_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            found_reg      <= 1'b0;
        end else begin
            if (cmd.scan_run) begin
                rd_pend_reg <= !issue_done_reg;
                if (!issue_done_reg) begin
                    issue_done_reg <= (scan_addr_reg == UA_W'(MEM_UNITS - 1));
                end
            end
            if (eval_en && take) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            scan_addr_reg <= '0;
            cur_len_reg   <= '0;
        end else begin
            if (cmd.scan_run && !issue_done_reg) begin
                scan_addr_reg <= scan_addr_reg + UA_W'(1);
            end
            if (cmd.scan_run) begin
                rd_unit_reg <= scan_addr_reg;
            end
            if (cmd.scan_run && rd_pend_reg) begin
                if (rd_data_reg == '0) begin
                    if (cur_len_reg == '0) begin
                        cur_start_reg <= rd_unit_reg;
                    end
                    cur_len_reg <= cur_len_reg + UC_W'(1);
                end else begin
                    cur_len_reg <= '0;
                end
            end
        end
        if (eval_en && take) begin
            pick_start_reg <= cur_start_reg;
            pick_len_reg   <= cur_len_reg;
        end
    end

    // ---- step counter ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_clear) begin
            cnt_reg <= '0;
        end else if (cmd.init_clear || cmd.mark_step || cmd.clear_step) begin
            cnt_reg <= cnt_reg + UC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.free_len_load) begin
            free_len_reg <= rd_data_reg;
        end
    end

    // ---- result register ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_status_reg <= cmd.out_status;
            if (cmd.out_status != STAT_OK) begin
                out_start_reg <= '0;
                out_slot_reg  <= '0;
                out_run_reg   <= '0;
            end else if (req_func_reg == FUNC_FREE) begin
                out_start_reg <= START_W'(slot_rd_reg);
                out_slot_reg  <= req_slot_reg;
                out_run_reg   <= RUN_W'(free_len_reg);
            end else begin
                out_start_reg <= START_W'(pick_start_reg);
                out_slot_reg  <= SLOT_W'(issued_reg);
                out_run_reg   <= RUN_W'(req_size_reg);
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}},
                       out_run_reg, out_slot_reg, out_start_reg, out_status_reg};

    // ---- status to controller ----
    always_comb begin
        sts.init_last  = (cnt_reg == UC_W'(MEM_UNITS - 1));
        sts.req_free   = (req_func_reg == FUNC_FREE);
        sts.req_reject = (req_size_reg == '0) || (issued_reg >= SC_W'(SLOTS));
        sts.slot_bad   = (32'(req_slot_reg) >= SLOTS) ||
                         !slot_valid_reg[SA_W'(req_slot_reg)];
        sts.scan_end   = rd_pend_reg && (rd_unit_reg == UA_W'(MEM_UNITS - 1));
        sts.found      = found_reg || (eval_en && take);
        sts.len_zero   = (rd_data_reg == '0);
        sts.mark_last  = (CMP_W'(cnt_reg) + CMP_W'(1)) == CMP_W'(req_size_reg);
        sts.clear_last = (CMP_W'(cnt_reg) + CMP_W'(1)) == CMP_W'(free_len_reg);
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    // ---- checks ----
    a_issued_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(issued_reg) <= SLOTS)
        else $error("slot issue count beyond table size");

    a_mark_in_map: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mark_step |-> (32'(pick_start_reg) + 32'(cnt_reg)) < MEM_UNITS)
        else $error("marking past the end of the unit map");

    a_ok_has_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (out_status_reg == STAT_OK)) |-> (out_run_reg != '0))
        else $error("successful result with empty run");

endmodule

@@ hdl/cfa_controller.sv @@
// ============================================================================
// cfa_controller - allocator sequencing state machine
// Walks each request through check, scan, mark or free, and result handoff.
// ============================================================================
module cfa_controller (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  cfa_pkg::sts_t sts,
    output cfa_pkg::cmd_t cmd
);
    import cfa_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    status_t code_reg;
    status_t code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_INIT;
            code_reg  <= STAT_OK;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        code_next      = code_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.out_status = code_reg;
        unique case (state_reg)
            FSM_INIT: begin
                cmd.init_clear = 1'b1;
                if (sts.init_last) begin
                    cmd.cnt_clear = 1'b1;
                    state_next    = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.req_load = 1'b1;
                    state_next   = FSM_CHECK;
                end
            end
            FSM_CHECK: begin
                code_next = STAT_OK;
                if (sts.req_free) begin
                    if (sts.slot_bad) begin
                        code_next  = STAT_NOTALLOC;
                        state_next = FSM_DONE;
                    end else begin
                        cmd.slot_rd = 1'b1;
                        state_next  = FSM_FREE_ADDR;
                    end
                end else if (sts.req_reject) begin
                    code_next  = STAT_FULL;
                    state_next = FSM_DONE;
                end else begin
                    cmd.scan_init = 1'b1;
                    state_next    = FSM_SCAN;
                end
            end
            FSM_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_end) begin
                    state_next = FSM_CLOSE;
                end
            end
            FSM_CLOSE: begin
                cmd.close_run = 1'b1;
                cmd.cnt_clear = 1'b1;
                if (sts.found) begin
                    state_next = FSM_MARK;
                end else begin
                    code_next  = STAT_NOFIT;
                    state_next = FSM_DONE;
                end
            end
            FSM_MARK: begin
                cmd.mark_step = 1'b1;
                if (sts.mark_last) begin
                    state_next = FSM_DONE;
                end
            end
            FSM_FREE_ADDR: begin
                cmd.free_rd = 1'b1;
                state_next  = FSM_FREE_LEN;
            end
            FSM_FREE_LEN: begin
                cmd.free_len_load = 1'b1;
                cmd.cnt_clear     = 1'b1;
                state_next        = sts.len_zero ? FSM_DONE : FSM_CLEAR;
            end
            FSM_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) begin
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load     = 1'b1;
                    cmd.alloc_commit = (code_reg == STAT_OK) && !sts.req_free;
                    cmd.free_commit  = (code_reg == STAT_OK) && sts.req_free;
                    state_next       = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    a_commit_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.alloc_commit || cmd.free_commit) |-> (cmd.out_load && code_reg == STAT_OK))
        else $error("table update without a successful result");

endmodule

@@ hdl/contiguous_fit_allocator_core.sv @@
// ============================================================================
// contiguous_fit_allocator_core - first/best/worst fit contiguous allocator
// Keeps a map of MEM_UNITS units and SLOTS partition records; serves one
// allocate or free request at a time and returns one result per request.
// ============================================================================
//
//  channel   direction  handshake            payload (lowest bit first)
//  --------  ---------  -------------------  ---------------------------------
//  request   in         s_tvalid / s_tready  func, req_size, slot
//  result    out        m_tvalid / m_tready  status, start_unit, slot_used,
//                                            run_size
//
//  Allocation: the unit map is scanned one unit per cycle through its single
//  read/write port and the chosen run is then marked one unit per cycle.
//  Free: slot lookup, start unit lookup, clear run.
//  Rejected requests go straight from the check to the result.
//  After reset the unit map is cleared; s_tready is low meanwhile.
//  A stalled result holds in the output register; the block then waits in its
//  final step before returning ready.
//
module contiguous_fit_allocator_core #(
    parameter int MEM_UNITS = cfa_pkg::MEM_UNITS_DEF,
    parameter int SLOTS     = cfa_pkg::SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request: func[1:0], req_size[8:2], slot[12:9], zero fill above
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cfa_pkg::S_TDATA_W-1:0] s_tdata,
    // result: status[1:0], start_unit[7:2], slot_used[11:8], run_size[18:12],
    // zero fill above
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cfa_pkg::M_TDATA_W-1:0] m_tdata
);
    import cfa_pkg::*;

    // command and status bundles between sequencer and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: owns the input handshake and the order of the steps
    cfa_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: unit map, slot table, run scanner, output register
    cfa_datapath #(
        .MEM_UNITS (MEM_UNITS),
        .SLOTS     (SLOTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ sim/tb.sv @@
// ============================================================================
// tb - self-checking testbench for contiguous_fit_allocator_core
// Drives allocate and free requests into the stream input, predicts every
// result with a behavioral copy of the unit map and slot table, and checks
// each result field by field. Directed requests cover rejects, a full-map
// allocation and the three fit policies; random traffic follows in three
// flow-control phases with a drain between them.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfa_pkg::*;

    localparam int UNITS       = MEM_UNITS_DEF;
    localparam int SLOT_CNT    = SLOTS_DEF;
    localparam int STALL_LIMIT = 4000;   // cycles without any accepted transaction
    localparam int TAIL_CYCLES = 200;    // quiet window after the last result

    typedef struct packed {
        status_t             status;
        logic [START_W-1:0]  start_unit;
        logic [SLOT_W-1:0]   slot_used;
        logic [RUN_W-1:0]    run_size;
    } alloc_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // behavioral copy of the allocator state
    logic [SIZE_W-1:0]  unit_owner [UNITS];
    logic [START_W-1:0] part_start [SLOT_CNT];
    bit                 part_live  [SLOT_CNT];
    int                 parts_issued;

    alloc_result_t pending_results[$];
    int            mismatch_count = 0;
    int            src_idle_pct   = 0;
    int            sink_idle_pct  = 0;

    contiguous_fit_allocator_core #(
        .MEM_UNITS (UNITS),
        .SLOTS     (SLOT_CNT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Apply one request to the behavioral state and return the result it yields.
    function automatic alloc_result_t apply_request(input func_t op,
                                                    input logic [SIZE_W-1:0] size,
                                                    input logic [SLOT_W-1:0] idx);
        alloc_result_t r;
        int u, run_len, pick_start, pick_len, first_u, n;
        bit found;
        r = '0;
        r.status = STAT_OK;
        if (op == FUNC_FREE) begin
            if (idx >= SLOT_CNT || !part_live[idx]) begin
                r.status = STAT_NOTALLOC;
            end else begin
                first_u = part_start[idx];
                n = unit_owner[first_u];
                for (u = first_u; u < first_u + n && u < UNITS; u++) unit_owner[u] = '0;
                part_live[idx] = 1'b0;
                r.start_unit = first_u[START_W-1:0];
                r.slot_used  = idx;
                r.run_size   = n[RUN_W-1:0];
            end
        end else if (size == 0 || parts_issued >= SLOT_CNT) begin
            r.status = STAT_FULL;
        end else begin
            // walk the map once; evaluate each free run where it ends
            found = 1'b0;
            pick_start = 0;
            pick_len = 0;
            run_len = 0;
            for (u = 0; u <= UNITS; u++) begin
                if (u < UNITS && unit_owner[u] == '0) begin
                    run_len++;
                end else begin
                    if (run_len != 0 && run_len >= size) begin
                        if (!found || (op == FUNC_BEST && run_len < pick_len) ||
                            (op == FUNC_WORST && run_len > pick_len)) begin
                            found = 1'b1;
                            pick_start = u - run_len;
                            pick_len = run_len;
                        end
                    end
                    run_len = 0;
                end
            end
            if (!found) begin
                r.status = STAT_NOFIT;
            end else begin
                for (u = pick_start; u < pick_start + size; u++) unit_owner[u] = size;
                part_start[parts_issued] = pick_start[START_W-1:0];
                part_live[parts_issued]  = 1'b1;
                r.start_unit = pick_start[START_W-1:0];
                r.slot_used  = parts_issued[SLOT_W-1:0];
                r.run_size   = size;
                parts_issued++;
            end
        end
        return r;
    endfunction

    // Send one request; entered and left at a falling edge.
    task automatic send_request(input func_t op, input logic [SIZE_W-1:0] size,
                                input logic [SLOT_W-1:0] idx);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[1:0]  = op;
        word[8:2]  = size;
        word[12:9] = idx;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_request(op, size, idx));
        @(negedge aclk);
    endtask

    // Hold the input idle until every expected result has come back.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    // Zero sizes, bad frees and oversize requests on an empty map.
    task automatic test_rejects();
        send_request(FUNC_FIRST, 7'd0, 4'd0);
        send_request(FUNC_BEST, 7'd0, 4'd5);
        send_request(FUNC_WORST, 7'd0, 4'd15);
        send_request(FUNC_FREE, 7'd0, 4'd0);
        send_request(FUNC_FREE, 7'd127, 4'd15);
        send_request(FUNC_FIRST, 7'd65, 4'd0);
        send_request(FUNC_WORST, 7'd127, 4'd15);
    endtask

    // Take the whole map in one run, fail on a full map, release it, double free.
    task automatic test_full_map();
        send_request(FUNC_FIRST, 7'd64, 4'd0);
        send_request(FUNC_BEST, 7'd1, 4'd0);
        send_request(FUNC_FREE, 7'd0, 4'd0);
        send_request(FUNC_FREE, 7'd0, 4'd0);
    endtask

    // Fill the map, punch holes of different lengths, then pick with each policy.
    task automatic test_fit_modes();
        send_request(FUNC_FIRST, 7'd10, 4'd0);
        send_request(FUNC_FIRST, 7'd5, 4'd0);
        send_request(FUNC_FIRST, 7'd20, 4'd0);
        send_request(FUNC_FIRST, 7'd3, 4'd0);
        send_request(FUNC_FIRST, 7'd26, 4'd0);
        send_request(FUNC_FREE, 7'd0, 4'd2);     // hole of 5 at unit 10
        send_request(FUNC_FREE, 7'd0, 4'd4);     // hole of 3 at unit 35
        send_request(FUNC_BEST, 7'd3, 4'd0);     // smallest adequate hole
        send_request(FUNC_FREE, 7'd0, 4'd6);
        send_request(FUNC_WORST, 7'd2, 4'd0);    // largest hole
        send_request(FUNC_WORST, 7'd3, 4'd0);    // equal holes: lowest start wins
    endtask

    // Random mix of allocations and frees; frees mostly target live slots.
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int count);
        int live[$];
        func_t op;
        logic [SIZE_W-1:0] size;
        logic [SLOT_W-1:0] idx;
        int pick;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        repeat (count) begin
            if ($urandom_range(0, 99) < 40) begin
                op   = FUNC_FREE;
                size = SIZE_W'($urandom);
                idx  = SLOT_W'($urandom);
                live.delete();
                for (int i = 0; i < SLOT_CNT; i++) if (part_live[i]) live.push_back(i);
                if (live.size() != 0 && $urandom_range(0, 99) < 70)
                    idx = SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
            end else begin
                op   = func_t'($urandom_range(0, 2));
                idx  = SLOT_W'($urandom);
                pick = $urandom_range(0, 99);
                if (pick < 5)       size = '0;
                else if (pick < 15) size = SIZE_W'($urandom_range(65, 127));
                else if (pick < 25) size = SIZE_W'($urandom_range(33, 64));
                else                size = SIZE_W'($urandom_range(1, 16));
            end
            send_request(op, size, idx);
        end
    endtask

    // Randomize the result-side ready at each falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin
        alloc_result_t want;
        alloc_result_t got;
        if (aresetn === 1'b1 && m_tvalid && m_tready) begin
            got.status     = status_t'(m_tdata[1:0]);
            got.start_unit = m_tdata[7:2];
            got.slot_used  = m_tdata[11:8];
            got.run_size   = m_tdata[18:12];
            if (pending_results.size() == 0) begin
                $error("result with none expected: %h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    mismatch_count++;
                end
                if (got.start_unit !== want.start_unit) begin
                    $error("start_unit: expected %0d, actual %0d",
                           want.start_unit, got.start_unit);
                    mismatch_count++;
                end
                if (got.slot_used !== want.slot_used) begin
                    $error("slot_used: expected %0d, actual %0d",
                           want.slot_used, got.slot_used);
                    mismatch_count++;
                end
                if (got.run_size !== want.run_size) begin
                    $error("run_size: expected %0d, actual %0d",
                           want.run_size, got.run_size);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (aresetn !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        aresetn  = 1'b0;
        for (int i = 0; i < UNITS; i++) unit_owner[i] = '0;
        for (int i = 0; i < SLOT_CNT; i++) begin
            part_start[i] = '0;
            part_live[i]  = 1'b0;
        end
        parts_issued = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        src_idle_pct  = 10;
        sink_idle_pct = 46;
        test_rejects();
        test_full_map();
        test_fit_modes();
        hold_until_drained();

        test_random_traffic(10, 46, 380);
        hold_until_drained();
        test_random_traffic(46, 10, 380);
        hold_until_drained();
        test_random_traffic(0, 0, 370);
        hold_until_drained();

        // watch for stray results after the last expected one
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
